FILE: hdl/cgam_pkg.sv
// Package for the coolant gauge average and map unit.
// Holds field widths, register indexes, reset values and warning codes.
// No dependencies.
package cgam_pkg;

  localparam int DATA_W        = 8;
  localparam int FS_W          = 16;
  localparam int LIM_W         = 9;
  localparam int DVD_W         = 24;
  localparam int DVS_W         = 9;
  localparam int POS_W         = DVD_W + 1;
  localparam int STEP_W        = 5;
  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 32;
  localparam int AVG_DEPTH_DEF = 16;

  localparam logic [DATA_W-1:0] TEMP_MIN_RST  = 8'd100;
  localparam logic [DATA_W-1:0] KNEE_TEMP_RST = 8'd135;
  localparam logic [DATA_W-1:0] RED_START_RST = 8'd150;
  localparam logic [DATA_W-1:0] TEMP_MAX_RST  = 8'd160;
  localparam logic [FS_W-1:0]   FULL_SCALE_RST = 16'd3600;
  localparam logic [DATA_W-1:0] WARN_ON_RST   = 8'd150;
  localparam logic [DATA_W-1:0] WARN_OFF_RST  = 8'd145;
  localparam logic [LIM_W-1:0]  BAD_LIMIT_RST = 9'd251;

  typedef enum logic [2:0] {
    REG_TEMP_MIN,
    REG_KNEE_TEMP,
    REG_RED_ZONE_START,
    REG_TEMP_MAX,
    REG_FULL_SCALE_STEPS,
    REG_WARN_ON_LEVEL,
    REG_WARN_OFF_LEVEL,
    REG_BAD_DATA_LIMIT
  } cgam_reg_t;

  typedef enum logic [1:0] {
    WARN_OFF,
    WARN_ON,
    WARN_OPEN
  } cgam_warn_t;

endpackage

FILE: hdl/cgam_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cgam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/coolant_gauge_average_and_map_unit.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | in_sample, in_timed_out, in_fresh, in_ignition_reset,
//          |                      | in_override
// result   | out_valid / out_ready| out_target_position, out_link_lost, out_avg_temp,
//          |                      | out_warning_status
// config   | APB psel/penable     | paddr, pwdata, prdata, pready
//
// An item that yields a result is mapped by the 24-step bit-serial divider of the dial map
// and then loaded into the output register; the next item can be taken in the cycle after that load.
// A lost link or a target pinned at zero or full scale skips the divider.
// An ignition reset refills the whole ring memory with the item, one entry a cycle.
// After reset the whole ring is cleared to zero before the first item is taken.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Depends on cgam_pkg and cgam_ram.
module coolant_gauge_average_and_map_unit
  import cgam_pkg::*;
#(
  parameter int AVG_DEPTH = AVG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DATA_W-1:0]  in_sample,
  input  logic               in_timed_out,
  input  logic               in_fresh,
  input  logic               in_ignition_reset,
  input  logic               in_override,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [FS_W-1:0]    out_target_position,
  output logic               out_link_lost,
  output logic [DATA_W-1:0]  out_avg_temp,
  output logic [1:0]         out_warning_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(AVG_DEPTH);
  localparam int SUM_W  = DATA_W + IDX_W;
  localparam int RCP_SH = SUM_W + IDX_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PRD_W  = 2 * SUM_W + 1;
  localparam logic [RCP_W-1:0] RCP_M =
    RCP_W'(((64'd1 << RCP_SH) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_UPD, S_FILL, S_AVG, S_MAP, S_DIVM, S_OUT
  } state_t;

  state_t state_r;

  logic [DATA_W-1:0] temp_min_r, knee_r, red_r, temp_max_r, warn_on_r, warn_off_r;
  logic [FS_W-1:0]   fs_r;
  logic [LIM_W-1:0]  bad_limit_r;

  logic [IDX_W-1:0]  idx_r, cnt_r;
  logic [SUM_W-1:0]  sum_r;
  logic [DATA_W-1:0] data_r, avg_r;
  logic              lost_r;
  cgam_warn_t        warn_state_r;
  logic [FS_W-1:0]   tgt_r, off_r;

  logic [DVD_W-1:0]  dvd_r, quo_r;
  logic [DVS_W-1:0]  dvs_r, rem_r;
  logic [STEP_W-1:0] step_r;

  logic              out_valid_r, out_lost_r;
  logic [FS_W-1:0]   out_tgt_r;
  logic [DATA_W-1:0] out_avg_r;
  logic [1:0]        out_warn_r;
  logic              out_load;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [DATA_W-1:0] mem_wdata, mem_rdata;

  logic              cfg_wr;
  logic              in_lost;
  logic [SUM_W-1:0]  sum_nxt;
  logic [IDX_W-1:0]  idx_nxt;

  logic [PRD_W-1:0]  avg_prod;
  logic [DATA_W-1:0] avg_div;

  logic [DVS_W:0]    trial;
  logic              trial_ge;
  logic [DVS_W-1:0]  rem_nxt;

  logic [17:0]       fs3;
  logic [FS_W-1:0]   three_q;
  logic [12:0]       eighth;
  logic [DATA_W-1:0] avg_q, num;
  logic [FS_W-1:0]   mul_a, map_off;
  logic [DATA_W-1:0] mul_b, map_dvs;
  logic              map_zero, map_full;
  logic [DVD_W-1:0]  prod;
  logic [POS_W-1:0]  pos_sum;
  logic [FS_W-1:0]   pos_sat;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_min_r  <= TEMP_MIN_RST;
      knee_r      <= KNEE_TEMP_RST;
      red_r       <= RED_START_RST;
      temp_max_r  <= TEMP_MAX_RST;
      fs_r        <= FULL_SCALE_RST;
      warn_on_r   <= WARN_ON_RST;
      warn_off_r  <= WARN_OFF_RST;
      bad_limit_r <= BAD_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cgam_reg_t'(paddr[4:2]))
        REG_TEMP_MIN:         temp_min_r  <= pwdata[DATA_W-1:0];
        REG_KNEE_TEMP:        knee_r      <= pwdata[DATA_W-1:0];
        REG_RED_ZONE_START:   red_r       <= pwdata[DATA_W-1:0];
        REG_TEMP_MAX:         temp_max_r  <= pwdata[DATA_W-1:0];
        REG_FULL_SCALE_STEPS: fs_r        <= pwdata[FS_W-1:0];
        REG_WARN_ON_LEVEL:    warn_on_r   <= pwdata[DATA_W-1:0];
        REG_WARN_OFF_LEVEL:   warn_off_r  <= pwdata[DATA_W-1:0];
        REG_BAD_DATA_LIMIT:   bad_limit_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cgam_reg_t'(paddr[4:2]))
      REG_TEMP_MIN:         prdata = PDATA_W'(temp_min_r);
      REG_KNEE_TEMP:        prdata = PDATA_W'(knee_r);
      REG_RED_ZONE_START:   prdata = PDATA_W'(red_r);
      REG_TEMP_MAX:         prdata = PDATA_W'(temp_max_r);
      REG_FULL_SCALE_STEPS: prdata = PDATA_W'(fs_r);
      REG_WARN_ON_LEVEL:    prdata = PDATA_W'(warn_on_r);
      REG_WARN_OFF_LEVEL:   prdata = PDATA_W'(warn_off_r);
      REG_BAD_DATA_LIMIT:   prdata = PDATA_W'(bad_limit_r);
      default:              prdata = '0;
    endcase
  end

  // Sample ring memory.
  cgam_ram #(
    .WIDTH(DATA_W),
    .DEPTH(AVG_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(idx_r),
    .rdata(mem_rdata)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = data_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = '0;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
      end
      S_UPD: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_lost  = in_timed_out || ({1'b0, in_sample} >= bad_limit_r);
  assign sum_nxt  = sum_r - SUM_W'(mem_rdata) + SUM_W'(data_r);
  assign idx_nxt  = (idx_r == IDX_W'(AVG_DEPTH - 1)) ? '0 : idx_r + 1'b1;

  // Ring average by reciprocal multiplication, exact over the whole range of the sum.
  assign avg_prod = PRD_W'(sum_r) * PRD_W'(RCP_M);
  assign avg_div  = avg_prod[RCP_SH +: DATA_W];

  // One restoring division step.
  assign trial    = {rem_r, dvd_r[DVD_W-1]};
  assign trial_ge = trial >= {1'b0, dvs_r};
  assign rem_nxt  = trial_ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);

  // Dial segment selection from the average.
  assign fs3     = {1'b0, fs_r, 1'b0} + {2'b00, fs_r};
  assign three_q = fs3[17:2];
  assign eighth  = fs_r[FS_W-1:3];
  assign avg_q   = avg_r;

  always_comb begin
    num      = '0;
    map_zero = 1'b0;
    map_full = 1'b0;
    if (avg_q <= knee_r) begin
      num      = (avg_q >= temp_min_r) ? avg_q - temp_min_r : '0;
      mul_a    = three_q;
      mul_b    = num;
      map_dvs  = knee_r - temp_min_r;
      map_off  = '0;
      map_zero = (num == '0) || (knee_r <= temp_min_r);
    end else if (avg_q <= red_r) begin
      mul_a    = FS_W'(eighth);
      mul_b    = avg_q - knee_r;
      map_dvs  = red_r - knee_r;
      map_off  = three_q;
    end else begin
      mul_a    = FS_W'(eighth);
      mul_b    = avg_q - red_r;
      map_dvs  = temp_max_r - red_r;
      map_off  = three_q + FS_W'(eighth);
      map_full = temp_max_r <= red_r;
    end
  end

  assign prod    = DVD_W'(mul_a) * DVD_W'(mul_b);
  assign pos_sum = POS_W'(quo_r) + POS_W'(off_r);
  assign pos_sat = (pos_sum > POS_W'(fs_r)) ? fs_r : pos_sum[FS_W-1:0];

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      idx_r        <= '0;
      sum_r        <= '0;
      warn_state_r <= WARN_OFF;
      out_valid_r  <= 1'b0;
      step_r       <= '0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(AVG_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (!in_override && (in_lost || in_fresh)) begin
              data_r <= in_lost ? '0 : in_sample;
              lost_r <= in_lost;
              cnt_r  <= '0;
              state_r <= in_ignition_reset ? S_FILL : S_UPD;
            end
          end
        end
        S_UPD: begin
          sum_r   <= sum_nxt;
          idx_r   <= idx_nxt;
          state_r <= S_AVG;
        end
        S_FILL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == IDX_W'(AVG_DEPTH - 1)) begin
            sum_r   <= SUM_W'(data_r) * SUM_W'(AVG_DEPTH);
            idx_r   <= idx_nxt;
            state_r <= S_AVG;
          end
        end
        S_AVG: begin
          if (lost_r) begin
            tgt_r        <= fs_r;
            avg_r        <= '0;
            warn_state_r <= WARN_OPEN;
            state_r      <= S_OUT;
          end else begin
            avg_r   <= avg_div;
            state_r <= S_MAP;
          end
        end
        S_DIVM: begin
          if (step_r != '0) begin
            dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
            rem_r  <= rem_nxt;
            quo_r  <= {quo_r[DVD_W-2:0], trial_ge};
            step_r <= step_r - 1'b1;
          end else begin
            tgt_r   <= pos_sat;
            state_r <= S_OUT;
          end
        end
        S_MAP: begin
          if (avg_q >= warn_on_r) begin
            warn_state_r <= WARN_ON;
          end else if (avg_q <= warn_off_r) begin
            warn_state_r <= WARN_OFF;
          end
          if (map_zero) begin
            tgt_r   <= '0;
            state_r <= S_OUT;
          end else if (map_full) begin
            tgt_r   <= fs_r;
            state_r <= S_OUT;
          end else begin
            dvd_r   <= prod;
            dvs_r   <= DVS_W'(map_dvs);
            off_r   <= map_off;
            rem_r   <= '0;
            quo_r   <= '0;
            step_r  <= STEP_W'(DVD_W);
            state_r <= S_DIVM;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_tgt_r   <= tgt_r;
        out_lost_r  <= lost_r;
        out_avg_r   <= avg_r;
        out_warn_r  <= warn_state_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_target_position = out_tgt_r;
  assign out_link_lost       = out_lost_r;
  assign out_avg_temp        = out_avg_r;
  assign out_warning_status  = out_warn_r;

endmodule

FILE: hdl/cgam_checker.sv
// Port-level checker for the coolant gauge average and map unit, with its bind.
// Depends on cgam_pkg.
module cgam_checker
  import cgam_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_timed_out,
  input logic              in_fresh,
  input logic              in_override,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FS_W-1:0]   out_target_position,
  input logic              out_link_lost,
  input logic [DATA_W-1:0] out_avg_temp,
  input logic [1:0]        out_warning_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_target_position)
      && $stable(out_link_lost) && $stable(out_avg_temp) && $stable(out_warning_status))
    else $error("Result item changed while stalled.");

  a_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_link_lost |-> out_avg_temp == '0 && out_warning_status == WARN_OPEN)
    else $error("Lost-link result without zero average and open status.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_override && (in_fresh || in_timed_out) |=> !in_ready)
    else $error("Second item taken while one is in work.");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("Result appeared one cycle after its item was taken.");

endmodule

bind coolant_gauge_average_and_map_unit cgam_checker u_cgam_checker (.*);
